// ===== design/tvdfvl_pkg.sv =====
// Package: constants, types and helper functions for the TVD face-value limiter.
`timescale 1ns / 1ps
`default_nettype none

package tvdfvl_pkg;

    localparam int DATA_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int THR_BITS  = 16;
    localparam int DIV_STEPS = 31;
    localparam int VL_STEPS  = FRAC_BITS + 1;
    localparam int PP_SPLIT  = FRAC_BITS + 1;

    // Pipeline stage map
    localparam int ST_IN   = 0;
    localparam int ST_SAT  = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_DIVE = ST_DIV0 + DIV_STEPS - 1;
    localparam int ST_R    = ST_DIVE + 1;
    localparam int ST_P    = ST_R + 1;
    localparam int ST_VL0  = ST_P + 1;
    localparam int ST_VLE  = ST_VL0 + VL_STEPS - 1;
    localparam int ST_PSI  = ST_VLE + 1;
    localparam int ST_PP   = ST_PSI + 1;
    localparam int ST_SUM  = ST_PP + 1;
    localparam int ST_OUT  = ST_SUM + 1;
    localparam int NSTG    = ST_OUT + 1;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCHEME    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic signed [35:0] Q_ONE   = 36'sd1 <<< FRAC_BITS;
    localparam logic signed [35:0] Q_TWO   = 36'sd2 <<< FRAC_BITS;
    localparam logic signed [35:0] Q_FOUR  = 36'sd4 <<< FRAC_BITS;
    localparam logic [31:0]        R_LIMIT = 32'd32767 << FRAC_BITS;
    localparam logic [47:0]        R_MAXQ  = 48'd32767;

    typedef enum logic [2:0] {
        SCH_UPWIND,
        SCH_CENTRAL,
        SCH_MINMOD,
        SCH_SMART,
        SCH_MUSCL,
        SCH_SUPERBEE,
        SCH_VAN_LEER,
        SCH_MC
    } t_scheme;

    typedef struct packed {
        t_scheme               scheme;
        logic [THR_BITS-1:0]   thr;
    } t_cfg;

    typedef struct packed {
        logic                  done;
        logic                  computed;
        logic [31:0]           face;
        logic signed [31:0]    cen;
        logic signed [32:0]    dcu;
        logic                  rneg;
        logic [32:0]           nabs;
        logic [32:0]           d;
        logic [33:0]           rem;
        logic [DIV_STEPS-1:0]  lo;
        logic [DIV_STEPS-1:0]  q;
        logic                  rsat;
        logic signed [31:0]    r;
        logic signed [32:0]    psi;
        logic                  vpos;
        logic [31:0]           vden;
        logic [32:0]           vrem;
        logic [VL_STEPS-1:0]   vlo;
        logic [VL_STEPS-1:0]   vq;
        logic signed [50:0]    pp_lo;
        logic signed [48:0]    pp_hi;
        logic signed [48:0]    sh;
    } t_slot;

    function automatic logic [31:0] f_sat(input logic signed [49:0] v);
        logic [31:0] res;
        if (v > 50'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [35:0] f_min(input logic signed [35:0] a,
                                                 input logic signed [35:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [35:0] f_max(input logic signed [35:0] a,
                                                 input logic signed [35:0] b);
        return (a > b) ? a : b;
    endfunction

    // Limiter for every scheme but van Leer, which needs a divider
    function automatic logic signed [32:0] f_psi(input t_scheme s,
                                                 input logic signed [31:0] r);
        logic signed [35:0] rw;
        logic signed [35:0] r2;
        logic signed [35:0] t;
        logic signed [35:0] res;
        rw  = 36'(r);
        r2  = rw <<< 1;
        t   = '0;
        res = '0;
        case (s)
            SCH_UPWIND:   res = '0;
            SCH_CENTRAL:  res = rw;
            SCH_MINMOD:   res = f_max('0, f_min(Q_ONE, rw));
            SCH_SMART: begin
                t   = (36'sd3 * rw + Q_ONE) >>> 2;
                res = f_max('0, f_min(f_min(Q_FOUR, t), r2));
            end
            SCH_MUSCL, SCH_MC: begin
                t   = (rw + Q_ONE) >>> 1;
                res = f_max('0, f_min(f_min(Q_TWO, t), r2));
            end
            SCH_SUPERBEE: res = f_max(f_max('0, f_min(r2, Q_ONE)), f_min(rw, Q_TWO));
            default:      res = '0;
        endcase
        return res[32:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/tvdfvl_datapath.sv =====
// Datapath: stage registers and per-stage arithmetic of the face-value pipeline.
`timescale 1ns / 1ps
`default_nettype none

module tvdfvl_datapath (
    input  wire                          i_clk,
    input  wire  [tvdfvl_pkg::NSTG-1:0]  i_en,
    input  tvdfvl_pkg::t_cfg             i_cfg,
    input  wire  signed [31:0]           i_vel,
    input  wire  signed [31:0]           i_up,
    input  wire  signed [31:0]           i_cen,
    input  wire  signed [31:0]           i_down,
    output logic [31:0]                  o_face,
    output logic                         o_computed
);

    tvdfvl_pkg::t_slot r_slot [tvdfvl_pkg::NSTG];
    tvdfvl_pkg::t_slot n_slot [tvdfvl_pkg::NSTG];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < tvdfvl_pkg::NSTG; k++) begin
            if (i_en[k]) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

    for (genvar k = 0; k < tvdfvl_pkg::NSTG; k++) begin : g_stg
        if (k == tvdfvl_pkg::ST_IN) begin : g_in
            logic signed [32:0] dcu;
            logic signed [32:0] ddc;
            logic signed [33:0] half;
            logic               near_zero;
            always_comb begin
                n_slot[k] = '0;
                dcu   = 33'(i_cen) - 33'(i_up);
                ddc   = 33'(i_down) - 33'(i_cen);
                half  = 34'(i_cen) + 34'(ddc >>> 1);
                n_slot[k].computed = !i_vel[31] && (i_vel != '0);
                n_slot[k].cen  = i_cen;
                n_slot[k].dcu  = dcu;
                n_slot[k].d    = dcu[32] ? 33'(-dcu) : 33'(dcu);
                n_slot[k].nabs = ddc[32] ? 33'(-ddc) : 33'(ddc);
                n_slot[k].rneg = ddc[32] ^ dcu[32];
                near_zero = n_slot[k].d <= 33'(i_cfg.thr);
                n_slot[k].done = !n_slot[k].computed || near_zero;
                if (!n_slot[k].computed) begin
                    n_slot[k].face = '0;
                end else if (i_cfg.scheme == tvdfvl_pkg::SCH_CENTRAL) begin
                    n_slot[k].face = tvdfvl_pkg::f_sat(50'(half));
                end else begin
                    n_slot[k].face = i_cen;
                end
            end
        end else if (k == tvdfvl_pkg::ST_SAT) begin : g_sat
            logic [47:0] lim;
            always_comb begin
                n_slot[k] = r_slot[k-1];
                lim = 48'(r_slot[k-1].d) * tvdfvl_pkg::R_MAXQ;
                n_slot[k].rsat = 48'(r_slot[k-1].nabs) >= lim;
                n_slot[k].rem  = 34'(r_slot[k-1].nabs >>
                                     (tvdfvl_pkg::DIV_STEPS - tvdfvl_pkg::FRAC_BITS));
                n_slot[k].lo   = {r_slot[k-1].nabs[tvdfvl_pkg::DIV_STEPS-
                                                   tvdfvl_pkg::FRAC_BITS-1:0],
                                  {tvdfvl_pkg::FRAC_BITS{1'b0}}};
                n_slot[k].q    = '0;
            end
        end else if (k >= tvdfvl_pkg::ST_DIV0 && k <= tvdfvl_pkg::ST_DIVE) begin : g_div
            logic [33:0] rem2;
            always_comb begin
                n_slot[k] = r_slot[k-1];
                rem2 = {r_slot[k-1].rem[32:0], r_slot[k-1].lo[tvdfvl_pkg::DIV_STEPS-1]};
                if (rem2 >= {1'b0, r_slot[k-1].d}) begin
                    n_slot[k].rem = rem2 - {1'b0, r_slot[k-1].d};
                    n_slot[k].q   = {r_slot[k-1].q[tvdfvl_pkg::DIV_STEPS-2:0], 1'b1};
                end else begin
                    n_slot[k].rem = rem2;
                    n_slot[k].q   = {r_slot[k-1].q[tvdfvl_pkg::DIV_STEPS-2:0], 1'b0};
                end
                n_slot[k].lo = r_slot[k-1].lo << 1;
            end
        end else if (k == tvdfvl_pkg::ST_R) begin : g_r
            logic [31:0] mag;
            always_comb begin
                n_slot[k] = r_slot[k-1];
                mag = r_slot[k-1].rsat ? tvdfvl_pkg::R_LIMIT : 32'(r_slot[k-1].q);
                n_slot[k].r = r_slot[k-1].rneg ? -$signed(mag) : $signed(mag);
            end
        end else if (k == tvdfvl_pkg::ST_P) begin : g_p
            logic [33:0] vnum;
            always_comb begin
                n_slot[k] = r_slot[k-1];
                n_slot[k].psi  = tvdfvl_pkg::f_psi(i_cfg.scheme, r_slot[k-1].r);
                n_slot[k].vpos = r_slot[k-1].r > 32'sd0;
                n_slot[k].vden = n_slot[k].vpos ?
                                 32'(tvdfvl_pkg::Q_ONE) + $unsigned(r_slot[k-1].r) :
                                 32'(tvdfvl_pkg::Q_ONE);
                vnum = (34'd1 << (2 * tvdfvl_pkg::FRAC_BITS + 1)) +
                       34'(n_slot[k].vden) - 34'd1;
                n_slot[k].vrem = 33'(vnum >> tvdfvl_pkg::VL_STEPS);
                n_slot[k].vlo  = vnum[tvdfvl_pkg::VL_STEPS-1:0];
                n_slot[k].vq   = '0;
            end
        end else if (k >= tvdfvl_pkg::ST_VL0 && k <= tvdfvl_pkg::ST_VLE) begin : g_vl
            logic [32:0] rem2;
            always_comb begin
                n_slot[k] = r_slot[k-1];
                rem2 = {r_slot[k-1].vrem[31:0], r_slot[k-1].vlo[tvdfvl_pkg::VL_STEPS-1]};
                if (rem2 >= {1'b0, r_slot[k-1].vden}) begin
                    n_slot[k].vrem = rem2 - {1'b0, r_slot[k-1].vden};
                    n_slot[k].vq   = {r_slot[k-1].vq[tvdfvl_pkg::VL_STEPS-2:0], 1'b1};
                end else begin
                    n_slot[k].vrem = rem2;
                    n_slot[k].vq   = {r_slot[k-1].vq[tvdfvl_pkg::VL_STEPS-2:0], 1'b0};
                end
                n_slot[k].vlo = r_slot[k-1].vlo << 1;
            end
        end else if (k == tvdfvl_pkg::ST_PSI) begin : g_psi
            always_comb begin
                n_slot[k] = r_slot[k-1];
                if (i_cfg.scheme == tvdfvl_pkg::SCH_VAN_LEER) begin
                    n_slot[k].psi = r_slot[k-1].vpos ?
                                    $signed(33'(tvdfvl_pkg::Q_TWO) - 33'(r_slot[k-1].vq)) :
                                    33'sd0;
                end
            end
        end else if (k == tvdfvl_pkg::ST_PP) begin : g_pp
            always_comb begin
                n_slot[k] = r_slot[k-1];
                n_slot[k].pp_lo = 51'(r_slot[k-1].psi) *
                                  $signed({1'b0, r_slot[k-1].dcu[tvdfvl_pkg::PP_SPLIT-1:0]});
                n_slot[k].pp_hi = 49'(r_slot[k-1].psi) *
                                  $signed(r_slot[k-1].dcu[32:tvdfvl_pkg::PP_SPLIT]);
            end
        end else if (k == tvdfvl_pkg::ST_SUM) begin : g_sum
            always_comb begin
                n_slot[k] = r_slot[k-1];
                n_slot[k].sh = r_slot[k-1].pp_hi +
                               49'(r_slot[k-1].pp_lo >>> tvdfvl_pkg::PP_SPLIT);
            end
        end else begin : g_out
            always_comb begin
                n_slot[k] = r_slot[k-1];
                if (!r_slot[k-1].done) begin
                    n_slot[k].face = tvdfvl_pkg::f_sat(50'(r_slot[k-1].sh) +
                                                       50'(r_slot[k-1].cen));
                end
            end
        end
    end

    assign o_face     = r_slot[tvdfvl_pkg::NSTG-1].face;
    assign o_computed = r_slot[tvdfvl_pkg::NSTG-1].computed;

endmodule

`default_nettype wire

// ===== design/tvd_face_value_limiter.sv =====
// Top level: TVD face-value limiter with handshake control and configuration registers.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one cell face per transfer:
//   face velocity and upwind, centre and downwind values, signed Q16.16.
//   Output channel o_out_valid / i_out_ready carries the limited face value
//   and a flag that is set when the velocity was positive.
//   One face per cycle is sustained while i_out_ready is high. The depth is set
//   by the ratio divider (one quotient bit per stage, 31 stages) followed by
//   the van Leer divider (17 stages) and the multiply / add stages.
//   Every stage holds its own valid bit; a stage loads whenever it is empty
//   or the stage ahead of it moves, so bubbles close up under a stall and the
//   input keeps taking transfers while a finished result waits at the output.
//   When the receiver stalls with every stage full, o_in_ready drops.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 limiter scheme, 1 small-difference threshold); other indexes are
//   ignored. Write only while the pipeline is empty.
//   Reset (synchronous, active low) empties the pipeline and sets the
//   scheme to upwind and the threshold to zero.
`timescale 1ns / 1ps
`default_nettype none

module tvd_face_value_limiter (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  signed [31:0]                    i_face_velocity,
    input  wire  signed [31:0]                    i_upwind_value,
    input  wire  signed [31:0]                    i_centre_value,
    input  wire  signed [31:0]                    i_downwind_value,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [31:0]                    o_face_value,
    output logic                                  o_face_computed,
    input  wire                                   i_cfg_we,
    input  wire  [tvdfvl_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire  [tvdfvl_pkg::THR_BITS-1:0]       i_cfg_data
);

    localparam int N = tvdfvl_pkg::NSTG;

    logic [N-1:0]                    r_vld;
    logic [N-1:0]                    n_vld;
    logic [N-1:0]                    w_en;
    tvdfvl_pkg::t_scheme             r_scheme;
    logic [tvdfvl_pkg::THR_BITS-1:0] r_thr;
    tvdfvl_pkg::t_cfg                w_cfg;
    logic [31:0]                     w_face;

    // A stage moves when it or any stage ahead of it is empty, or the output drains
    for (genvar k = 0; k < N; k++) begin : g_en
        assign w_en[k] = i_out_ready || !(&r_vld[N-1:k]);
    end

    assign n_vld = (w_en & {r_vld[N-2:0], i_in_valid}) | (~w_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= tvdfvl_pkg::SCH_UPWIND;
            r_thr    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tvdfvl_pkg::CFG_SCHEME:    r_scheme <= tvdfvl_pkg::t_scheme'(i_cfg_data[2:0]);
                tvdfvl_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg = '{scheme: r_scheme, thr: r_thr};

    tvdfvl_datapath u_dp (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_cfg      (w_cfg),
        .i_vel      (i_face_velocity),
        .i_up       (i_upwind_value),
        .i_cen      (i_centre_value),
        .i_down     (i_downwind_value),
        .o_face     (w_face),
        .o_computed (o_face_computed)
    );

    assign o_in_ready   = w_en[0];
    assign o_out_valid  = r_vld[N-1];
    assign o_face_value = $signed(w_face);

endmodule

`default_nettype wire

// ===== design/tvdfvl_checker.sv =====
// Checker: port-level assertions for the face-value limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tvdfvl_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_ready,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire signed [31:0] i_face_value,
    input wire               i_face_computed
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    a_skipped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_face_computed |-> i_face_value == 32'sd0)
        else $error("non-computed face carries a value");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transfer");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_face_value) && $stable(i_face_computed))
        else $error("output payload changed under stall");

endmodule

bind tvd_face_value_limiter tvdfvl_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (o_in_ready),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_face_value    (o_face_value),
    .i_face_computed (o_face_computed)
);

`default_nettype wire
